// ----- sv/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on the rising clock, ignored while reset is high.
`define CHK_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("rf decoder port check failed");

// Check a property on the rising clock, reset cycles included.
`define CHK_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("rf decoder port check failed");

`endif

// ----- sv/rfpwd_pkg.sv -----
package rfpwd_pkg;

  // Field and register widths
  localparam int CODE_W    = 25;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_TIMEOUT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_MIN     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_MAX      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_TIMEOUT  = 2'd3;

  // Register reset values
  localparam logic [CFG_W-1:0] SYNC_TIMEOUT_RST = 16'd200;
  localparam logic [CFG_W-1:0] SYNC_MIN_RST     = 16'd50;
  localparam logic [CFG_W-1:0] ONE_MAX_RST      = 16'd30;
  localparam logic [CFG_W-1:0] GAP_TIMEOUT_RST  = 16'd1500;

  // Input item kinds
  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_START = 1'b1;

  // Result status codes
  localparam logic STATUS_FRAME      = 1'b0;
  localparam logic STATUS_SHORT_SYNC = 1'b1;

  typedef struct packed {
    logic kind;
    logic pin_level;
  } in_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              status;
  } out_t;

endpackage

// ----- sv/rf_remote_pulse_width_decoder.sv -----
// Pulse-width RF remote decoder. Takes one item per clock cycle, back to back: either a
// start request or one pin sample per microsecond tick. Each item goes through one pass
// of phase logic (sync, high, gap) and a saturating phase counter, and any result (a
// decoded frame, or the last stored code flagged as a short sync) lands in an output
// register on the cycle after the transfer. Input stalls only while that output
// register holds a result that the consumer is stalling. Frames are FRAME_BITS long,
// MSB first; code shows the low 25 bits. Write the timing registers only while idle.
module rf_remote_pulse_width_decoder #(
  parameter int FRAME_BITS  = 25,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  rfpwd_pkg::in_t                      in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output rfpwd_pkg::out_t                     out_data,
  input  logic                                cfg_we,
  input  logic [rfpwd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rfpwd_pkg::CFG_W-1:0]         cfg_data
);

  localparam int CODE_W = rfpwd_pkg::CODE_W;
  localparam int CFG_W  = rfpwd_pkg::CFG_W;
  localparam int BIT_W  = (FRAME_BITS > 1) ? $clog2(FRAME_BITS) : 1;
  localparam int CMP_W  = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;
  localparam logic [BIT_W-1:0]       LAST_BIT = BIT_W'(FRAME_BITS - 1);
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX  = {COUNT_WIDTH{1'b1}};
  localparam logic [COUNT_WIDTH-1:0] CNT_ONE  = COUNT_WIDTH'(1);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_SYNC = 2'd1,
    PH_HIGH = 2'd2,
    PH_GAP  = 2'd3
  } phase_t;

  // Timing registers
  logic [CFG_W-1:0] sync_timeout;
  logic [CFG_W-1:0] sync_min;
  logic [CFG_W-1:0] one_max;
  logic [CFG_W-1:0] gap_timeout;

  // Decoder state
  phase_t                  phase, phase_next;
  logic [COUNT_WIDTH-1:0]  phase_count, phase_count_next;
  logic [BIT_W-1:0]        bit_index, bit_index_next;
  logic [FRAME_BITS-1:0]   shift_bits, shift_bits_next;
  logic [CODE_W-1:0]       stored_code, stored_code_next;

  logic              in_xfer;
  logic              res_valid;
  logic              res_status;
  logic [CMP_W-1:0]  cnt_ext;
  logic [CFG_W-1:0]  sync_eff;
  logic [CFG_W-1:0]  gap_eff;
  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic              cnt_below_one;

  assign in_stall = out_valid & out_stall;
  assign in_xfer  = in_valid & ~in_stall;

  // Zero timeout acts as one
  assign sync_eff = (sync_timeout == '0) ? CFG_W'(1) : sync_timeout;
  assign gap_eff  = (gap_timeout == '0) ? CFG_W'(1) : gap_timeout;

  assign cnt_ext       = CMP_W'(phase_count);
  assign cnt_inc       = (phase_count == CNT_MAX) ? CNT_MAX : phase_count + CNT_ONE;
  assign cnt_below_one = cnt_ext < CMP_W'(one_max);

  // One pass of phase logic per item; the ending sample is handed to the next phase
  always_comb begin
    logic enter_high;
    logic [FRAME_BITS-1:0] base;
    enter_high       = 1'b0;
    base             = shift_bits;
    phase_next       = phase;
    phase_count_next = phase_count;
    bit_index_next   = bit_index;
    shift_bits_next  = shift_bits;
    stored_code_next = stored_code;
    res_valid        = 1'b0;
    res_status       = rfpwd_pkg::STATUS_FRAME;
    if (in_data.kind == rfpwd_pkg::KIND_START) begin
      phase_next       = PH_SYNC;
      phase_count_next = '0;
      bit_index_next   = '0;
      shift_bits_next  = '0;
    end else begin
      case (phase)
        PH_IDLE: begin
        end
        PH_SYNC: begin
          if (!in_data.pin_level && cnt_ext < CMP_W'(sync_eff)) begin
            phase_count_next = cnt_inc;
          end else if (cnt_ext <= CMP_W'(sync_min)) begin
            phase_next       = PH_IDLE;
            phase_count_next = '0;
            res_valid        = 1'b1;
            res_status       = rfpwd_pkg::STATUS_SHORT_SYNC;
          end else begin
            enter_high     = 1'b1;
            base           = '0;
            bit_index_next = '0;
          end
        end
        PH_HIGH: begin
          if (in_data.pin_level) begin
            phase_count_next = cnt_inc;
          end else begin
            shift_bits_next  = (shift_bits << 1) | FRAME_BITS'(cnt_below_one);
            phase_next       = PH_GAP;
            phase_count_next = CNT_ONE;
          end
        end
        PH_GAP: begin
          if (!in_data.pin_level && cnt_ext < CMP_W'(gap_eff)) begin
            phase_count_next = cnt_inc;
          end else if (bit_index == LAST_BIT) begin
            stored_code_next = CODE_W'(shift_bits);
            phase_next       = PH_IDLE;
            phase_count_next = '0;
            bit_index_next   = '0;
            res_valid        = 1'b1;
            res_status       = rfpwd_pkg::STATUS_FRAME;
          end else begin
            enter_high     = 1'b1;
            bit_index_next = bit_index + BIT_W'(1);
          end
        end
        default: begin
        end
      endcase
      // Start a high phase with the ending sample; a low sample closes it at once
      if (enter_high) begin
        if (in_data.pin_level) begin
          shift_bits_next  = base;
          phase_next       = PH_HIGH;
          phase_count_next = CNT_ONE;
        end else begin
          shift_bits_next  = (base << 1) | FRAME_BITS'(one_max != '0);
          phase_next       = PH_GAP;
          phase_count_next = CNT_ONE;
        end
      end
    end
  end

  // Hold configuration, advance state on each transfer, load the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_timeout <= rfpwd_pkg::SYNC_TIMEOUT_RST;
      sync_min     <= rfpwd_pkg::SYNC_MIN_RST;
      one_max      <= rfpwd_pkg::ONE_MAX_RST;
      gap_timeout  <= rfpwd_pkg::GAP_TIMEOUT_RST;
      phase        <= PH_IDLE;
      phase_count  <= '0;
      bit_index    <= '0;
      shift_bits   <= '0;
      stored_code  <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          rfpwd_pkg::REG_SYNC_TIMEOUT: sync_timeout <= cfg_data;
          rfpwd_pkg::REG_SYNC_MIN:     sync_min     <= cfg_data;
          rfpwd_pkg::REG_ONE_MAX:      one_max      <= cfg_data;
          rfpwd_pkg::REG_GAP_TIMEOUT:  gap_timeout  <= cfg_data;
          default: begin
          end
        endcase
      end
      if (in_xfer) begin
        phase       <= phase_next;
        phase_count <= phase_count_next;
        bit_index   <= bit_index_next;
        shift_bits  <= shift_bits_next;
        stored_code <= stored_code_next;
      end
      // Drop a taken result; load a new one when the item produces it
      if (in_xfer) begin
        out_valid <= res_valid;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload, loaded only with a new result
  always_ff @(posedge clk) begin
    if (in_xfer && res_valid) begin
      out_data.code   <= stored_code_next;
      out_data.status <= res_status;
    end
  end

endmodule

// ----- sv/rfpwd_checker.sv -----
`include "assert_macros.svh"

module rfpwd_checker (
  input logic            clk,
  input logic            rst,
  input logic            in_valid,
  input logic            in_stall,
  input rfpwd_pkg::in_t  in_data,
  input logic            out_valid,
  input logic            out_stall,
  input rfpwd_pkg::out_t out_data
);

  // Stalled result holds its payload
  `CHK_ASSERT(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid && $stable(out_data))

  // Input stalls only behind a stalled result
  `CHK_ASSERT(a_in_stall_cause, clk, rst, in_stall |-> out_valid && out_stall)

  // A start request transfer yields no result
  `CHK_ASSERT(a_start_quiet, clk, rst,
    in_valid && !in_stall && in_data.kind == rfpwd_pkg::KIND_START |=> !out_valid)

  // Reset leaves no result pending
  `CHK_ASSERT_ALWAYS(a_rst_empty, clk, rst |=> !out_valid)

endmodule

bind rf_remote_pulse_width_decoder rfpwd_checker u_rfpwd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
